[sv/spt_pkg.sv]
`default_nettype none
package spt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_PTE       = 2'd1;
  localparam logic [1:0] CMD_FLUSH     = 2'd2;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] ACC_LOAD  = 2'd0;
  localparam logic [1:0] ACC_STORE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;
  localparam logic [1:0] ACC_RSVD  = 2'd3;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_INVALID = 2'd2;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam logic [3:0] MODE_SV39 = 4'd8;
  localparam logic [3:0] MODE_SV48 = 4'd9;
  localparam logic [3:0] MODE_SV57 = 4'd10;

  localparam logic [2:0] REG_ROOT_PPN = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_MPRV     = 3'd2;
  localparam logic [2:0] REG_MPP      = 3'd3;
  localparam logic [2:0] REG_MXR      = 3'd4;
  localparam logic [2:0] REG_SUM      = 3'd5;

  localparam logic [31:0] AGE_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic        ok;
    logic        need_wb;
    logic [63:0] new_pte;
  } perm_t;

  function automatic logic [8:0] vpn_sel(input logic [63:0] va, input logic [2:0] lvl);
    logic [8:0] v;
    case (lvl)
      3'd0: v = va[20:12];
      3'd1: v = va[29:21];
      3'd2: v = va[38:30];
      3'd3: v = va[47:39];
      3'd4: v = va[56:48];
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/spt_perm.sv]
`default_nettype none
module spt_perm (
  input  wire logic [63:0]   pte,
  input  wire logic [1:0]    acc,
  input  wire logic [1:0]    eff,
  input  wire logic          sum,
  input  wire logic          mxr,
  output spt_pkg::perm_t     res
);
  logic r, w, x, u, a, d, ok;

  always_comb begin
    r = pte[1];
    w = pte[2];
    x = pte[3];
    u = pte[4];
    a = pte[6];
    d = pte[7];
    ok = 1'b1;
    if (!r && w) ok = 1'b0;
    if (eff == spt_pkg::PRIV_INVALID) ok = 1'b0;
    if (u && eff != spt_pkg::PRIV_USER && (!sum || acc == spt_pkg::ACC_FETCH)) ok = 1'b0;
    if (!u && eff != spt_pkg::PRIV_SUPER) ok = 1'b0;
    if (acc == spt_pkg::ACC_LOAD && !(r || (x && mxr))) ok = 1'b0;
    if (acc == spt_pkg::ACC_STORE && !w) ok = 1'b0;
    if (acc == spt_pkg::ACC_FETCH && !x) ok = 1'b0;
    res.ok = ok;
    res.need_wb = !a || (acc == spt_pkg::ACC_STORE && !d);
    res.new_pte = pte | 64'h40 | ((acc == spt_pkg::ACC_STORE) ? 64'h80 : 64'h0);
  end
endmodule
`default_nettype wire

[sv/sv_page_translation_unit.sv]
`default_nettype none
// RISC-V Sv39/Sv48/Sv57 translation unit with a fully associative TLB.
// Input stream s_*: s_tuser carries the command (translate, PTE data, flush).
// Output stream m_*: m_tuser carries the result kind (done, PTE read, PTE
// write); m_tlast marks the final result of an input transaction.
// A translate that misses emits a PTE read request; each PTE returned with
// the PTE command either emits the next read, a fault, or the final result
// (preceded by a PTE write when A or D must be set).
// One input transaction is handled at a time; s_tready is low unless the
// sequencer is idle, which includes a walk awaiting PTE data. Bare,
// machine-mode and non-canonical translates skip the TLB and go to the output.
// TLB lookup: one tag compare per cycle, stopping at the first hit or after
// the last entry, then an aging step, then on a miss one age compare per
// cycle over all entries to pick the oldest entry as the victim.
// A stalled m_tready holds the output register and the sequencer waits.
// Reset (synchronous, rst high) invalidates the TLB, zeroes ages and the
// configuration registers and drops any walk in progress.
// Config writes (cfg_we) to root PPN or mode flush the TLB.
module sv_page_translation_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [43:0]   cfg_data,
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  input  wire logic [135:0]  s_tdata,  // virtual_address, access_kind, privilege, pte_word
  input  wire logic [1:0]    s_tuser,  // cmd
  output      logic          m_tvalid,
  input  wire logic          m_tready,
  output      logic [135:0]  m_tdata,  // address, write_data, page_fault
  output      logic [1:0]    m_tuser,  // result_kind
  output      logic          m_tlast
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HIT   = 4'd1;
  localparam logic [3:0] S_AGE   = 4'd2;
  localparam logic [3:0] S_VICT  = 4'd3;
  localparam logic [3:0] S_PTE   = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_OUT1  = 4'd6;
  localparam logic [3:0] S_OUT2  = 4'd7;
  localparam logic [spt_pkg::IDX_W-1:0] IDX_LAST = spt_pkg::IDX_W'(spt_pkg::TLB_ENTRIES - 1);

  logic [3:0]  state;
  logic [43:0] root_ppn;
  logic [3:0]  mode;
  logic        mprv, mxr, sum;
  logic [1:0]  mpp;

  logic                      tlb_valid [spt_pkg::TLB_ENTRIES];
  logic [31:0]               tlb_age   [spt_pkg::TLB_ENTRIES];
  logic [51:0]               tlb_vp    [spt_pkg::TLB_ENTRIES];
  logic [63:0]               tlb_pte   [spt_pkg::TLB_ENTRIES];
  logic [55:0]               tlb_loc   [spt_pkg::TLB_ENTRIES];
  logic [55:0]               tlb_pbase [spt_pkg::TLB_ENTRIES];

  logic [spt_pkg::IDX_W-1:0] idx, hit_idx, victim, cur_k;
  logic                      hit_found;
  logic [31:0]               best;
  logic                      walk_busy;
  logic [2:0]                walk_level;
  logic [55:0]               walk_base;
  logic [63:0]               req_va, pte_reg;
  logic [1:0]                req_acc, req_eff;

  logic [1:0]  a_kind, b_kind;
  logic [63:0] a_addr, a_data, b_addr;
  logic        a_fault, a_last, has_b;

  logic [63:0] in_va;
  logic [1:0]  in_acc, in_priv, in_eff;
  logic [2:0]  levels;
  logic        canon;
  logic        out_free;

  logic        p_v, p_r, p_w, p_x;
  logic [43:0] p_ppn, lowmask;
  logic [55:0] p_loc, physmask, next_base;
  logic        fill_en, wb_en;
  spt_pkg::perm_t perm;

  spt_perm u_perm (
    .pte (tlb_pte[cur_k]),
    .acc (req_acc),
    .eff (req_eff),
    .sum (sum),
    .mxr (mxr),
    .res (perm)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    in_va   = s_tdata[63:0];
    in_acc  = (s_tdata[65:64] == spt_pkg::ACC_RSVD) ? spt_pkg::ACC_LOAD : s_tdata[65:64];
    in_priv = s_tdata[67:66];
    in_eff  = (in_acc != spt_pkg::ACC_FETCH && mprv) ? mpp : in_priv;
    case (mode)
      spt_pkg::MODE_SV39: levels = 3'd3;
      spt_pkg::MODE_SV48: levels = 3'd4;
      spt_pkg::MODE_SV57: levels = 3'd5;
      default:            levels = 3'd0;
    endcase
    case (levels)
      3'd3:    canon = (in_va[63:38] == '0) || (in_va[63:38] == '1);
      3'd4:    canon = (in_va[63:47] == '0) || (in_va[63:47] == '1);
      3'd5:    canon = (in_va[63:56] == '0) || (in_va[63:56] == '1);
      default: canon = 1'b1;
    endcase
    p_v   = pte_reg[0];
    p_r   = pte_reg[1];
    p_w   = pte_reg[2];
    p_x   = pte_reg[3];
    p_ppn = pte_reg[53:10];
    p_loc = walk_base + {44'd0, spt_pkg::vpn_sel(req_va, walk_level), 3'd0};
    case (walk_level)
      3'd1:    lowmask = 44'h1ff;
      3'd2:    lowmask = 44'h3ffff;
      3'd3:    lowmask = 44'h7ffffff;
      3'd4:    lowmask = 44'hfffffffff;
      default: lowmask = 44'h0;
    endcase
    physmask  = {lowmask, 12'd0};
    next_base = {p_ppn, 12'd0};
    fill_en = (state == S_PTE) && p_v && !(!p_r && p_w) && (p_r || p_x)
              && ((p_ppn & lowmask) == '0);
    wb_en   = (state == S_CHECK) && perm.ok && perm.need_wb;
  end

  // TLB payload
  always_ff @(posedge clk) begin
    if (fill_en) begin
      tlb_vp[victim]    <= req_va[63:12];
      tlb_pte[victim]   <= pte_reg;
      tlb_loc[victim]   <= p_loc;
      tlb_pbase[victim] <= next_base | (req_va[55:0] & physmask);
    end else if (wb_en) begin
      tlb_pte[cur_k] <= perm.new_pte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      root_ppn <= '0;
      mode <= '0;
      mprv <= 1'b0;
      mpp <= '0;
      mxr <= 1'b0;
      sum <= 1'b0;
      for (int k = 0; k < spt_pkg::TLB_ENTRIES; k++) begin
        tlb_valid[k] <= 1'b0;
        tlb_age[k] <= '0;
      end
      idx <= '0;
      hit_idx <= '0;
      hit_found <= 1'b0;
      victim <= '0;
      cur_k <= '0;
      best <= '0;
      walk_busy <= 1'b0;
      walk_level <= '0;
      walk_base <= '0;
      req_va <= '0;
      req_acc <= '0;
      req_eff <= '0;
      has_b <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT1 && state != S_OUT2) m_tvalid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          spt_pkg::REG_ROOT_PPN: root_ppn <= cfg_data;
          spt_pkg::REG_MODE:     mode <= cfg_data[3:0];
          spt_pkg::REG_MPRV:     mprv <= cfg_data[0];
          spt_pkg::REG_MPP:      mpp <= cfg_data[1:0];
          spt_pkg::REG_MXR:      mxr <= cfg_data[0];
          spt_pkg::REG_SUM:      sum <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index == spt_pkg::REG_ROOT_PPN || cfg_index == spt_pkg::REG_MODE) begin
          for (int k = 0; k < spt_pkg::TLB_ENTRIES; k++) begin
            tlb_valid[k] <= 1'b0;
            tlb_age[k] <= '0;
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            a_data <= '0;
            a_last <= 1'b1;
            has_b  <= 1'b0;
            case (s_tuser)
              spt_pkg::CMD_TRANSLATE: begin
                if (!walk_busy) begin
                  req_va  <= in_va;
                  req_acc <= in_acc;
                  req_eff <= in_eff;
                  a_kind  <= spt_pkg::KIND_DONE;
                  if (levels == 3'd0 || in_eff == spt_pkg::PRIV_MACHINE) begin
                    a_addr  <= in_va;
                    a_fault <= 1'b0;
                    state   <= S_OUT1;
                  end else if (!canon) begin
                    a_addr  <= '0;
                    a_fault <= 1'b1;
                    state   <= S_OUT1;
                  end else begin
                    idx <= '0;
                    hit_found <= 1'b0;
                    state <= S_HIT;
                  end
                end
              end
              spt_pkg::CMD_PTE: begin
                if (walk_busy) begin
                  pte_reg <= s_tdata[131:68];
                  state <= S_PTE;
                end
              end
              spt_pkg::CMD_FLUSH: begin
                for (int k = 0; k < spt_pkg::TLB_ENTRIES; k++) begin
                  tlb_valid[k] <= 1'b0;
                  tlb_age[k] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_HIT: begin
          if (tlb_valid[idx] && tlb_vp[idx] == req_va[63:12]) begin
            hit_found <= 1'b1;
            hit_idx <= idx;
            state <= S_AGE;
          end else if (idx == IDX_LAST) begin
            state <= S_AGE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_AGE: begin
          for (int k = 0; k < spt_pkg::TLB_ENTRIES; k++) begin
            if (hit_found && spt_pkg::IDX_W'(k) == hit_idx) tlb_age[k] <= '0;
            else if (tlb_age[k] != spt_pkg::AGE_MAX) tlb_age[k] <= tlb_age[k] + 32'd1;
          end
          if (hit_found) begin
            cur_k <= hit_idx;
            state <= S_CHECK;
          end else begin
            idx <= '0;
            best <= '0;
            victim <= '0;
            state <= S_VICT;
          end
        end
        S_VICT: begin
          if (tlb_age[idx] > best) begin
            best <= tlb_age[idx];
            victim <= idx;
          end
          if (idx == IDX_LAST) begin
            walk_busy  <= 1'b1;
            walk_level <= levels - 3'd1;
            walk_base  <= {root_ppn, 12'd0};
            a_kind  <= spt_pkg::KIND_READ;
            a_addr  <= {8'd0, {root_ppn, 12'd0}
                       + {44'd0, spt_pkg::vpn_sel(req_va, levels - 3'd1), 3'd0}};
            a_fault <= 1'b0;
            state <= S_OUT1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_PTE: begin
          a_kind  <= spt_pkg::KIND_DONE;
          a_addr  <= '0;
          a_fault <= 1'b1;
          state   <= S_OUT1;
          if (!p_v || (!p_r && p_w)) begin
            walk_busy <= 1'b0;
          end else if (!p_r && !p_x) begin
            if (walk_level == 3'd0) begin
              walk_busy <= 1'b0;
            end else begin
              walk_base  <= next_base;
              walk_level <= walk_level - 3'd1;
              a_kind  <= spt_pkg::KIND_READ;
              a_fault <= 1'b0;
              a_addr  <= {8'd0, next_base
                         + {44'd0, spt_pkg::vpn_sel(req_va, walk_level - 3'd1), 3'd0}};
            end
          end else begin
            walk_busy <= 1'b0;
            if (fill_en) begin
              tlb_valid[victim] <= 1'b1;
              tlb_age[victim] <= '0;
              cur_k <= victim;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          b_kind <= spt_pkg::KIND_DONE;
          b_addr <= {8'd0, tlb_pbase[cur_k]} | {52'd0, req_va[11:0]};
          if (!perm.ok) begin
            a_kind  <= spt_pkg::KIND_DONE;
            a_addr  <= '0;
            a_data  <= '0;
            a_fault <= 1'b1;
            a_last  <= 1'b1;
            has_b   <= 1'b0;
          end else if (perm.need_wb) begin
            a_kind  <= spt_pkg::KIND_WRITE;
            a_addr  <= {8'd0, tlb_loc[cur_k]};
            a_data  <= perm.new_pte;
            a_fault <= 1'b0;
            a_last  <= 1'b0;
            has_b   <= 1'b1;
          end else begin
            a_kind  <= spt_pkg::KIND_DONE;
            a_addr  <= {8'd0, tlb_pbase[cur_k]} | {52'd0, req_va[11:0]};
            a_data  <= '0;
            a_fault <= 1'b0;
            a_last  <= 1'b1;
            has_b   <= 1'b0;
          end
          state <= S_OUT1;
        end
        S_OUT1: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= a_kind;
            m_tdata  <= {7'd0, a_fault, a_data, a_addr};
            m_tlast  <= a_last;
            state    <= has_b ? S_OUT2 : S_IDLE;
          end
        end
        S_OUT2: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= b_kind;
            m_tdata  <= {72'd0, b_addr};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pte_ignored_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == spt_pkg::CMD_PTE && !walk_busy) |=> state == S_IDLE)
    else $error("PTE data accepted without a walk started work");

  a_read_no_fault: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == spt_pkg::KIND_READ) |-> (!m_tdata[128] && m_tlast))
    else $error("PTE read request flagged as fault or not last");

  a_hit_age_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE && hit_found) |=> tlb_age[hit_idx] == '0)
    else $error("hit entry age not cleared");

  a_walk_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_VICT && idx == IDX_LAST) |=> walk_busy)
    else $error("walk not started after victim search");

endmodule
`default_nettype wire
